@@ rtl/dip_pkg.sv @@
// Shared types and constants for the dotted IPv4 text parser.
// Every other file of the block imports this package; it depends on nothing.
package dip_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned AddrW  = 32;
  localparam int unsigned PartW  = 8;
  localparam int unsigned CountW = 3;

  // Part phase codes.
  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_ZERO   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;

  // Radix codes.
  localparam logic [1:0] RX_DEC = 2'd0;
  localparam logic [1:0] RX_OCT = 2'd1;
  localparam logic [1:0] RX_HEX = 2'd2;

  // Scan status codes.
  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_STOP = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  localparam logic [CountW-1:0] MaxParts = 3'd4;

  // Character codes.
  localparam logic [CharW-1:0] ChNul   = 8'h00;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;
  localparam logic [CharW-1:0] ChLowA  = 8'h61;
  localparam logic [CharW-1:0] ChLowF  = 8'h66;
  localparam logic [CharW-1:0] ChUpA   = 8'h41;
  localparam logic [CharW-1:0] ChUpF   = 8'h46;
  localparam logic [CharW-1:0] ChLowX  = 8'h78;
  localparam logic [CharW-1:0] ChUpX   = 8'h58;
  localparam logic [CharW-1:0] ChDot   = 8'h2e;
  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChTab   = 8'h09;
  localparam logic [CharW-1:0] ChCr    = 8'h0d;

  typedef struct packed {
    logic [AddrW-1:0] address;
    logic             parse_error;
  } res_t;

endpackage

@@ rtl/dotted_ipv4_text_parser.sv @@
// Dotted IPv4 text parser: one address string in, one byte per item.
// A terminating zero byte goes through the input register, then the result register.
// Throughput: one byte per cycle; only a terminator waits, while the result register is stalled.
// Reset (rst_ni low, asynchronous) empties both registers and returns the parser
// to the start of a new string.
// Depends on dip_pkg, dip_in_reg, dip_core and dip_out_reg.
module dotted_ipv4_text_parser import dip_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [CharW-1:0] char_in_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [AddrW-1:0] address_o,
  output logic             parse_error_o
);

  logic             hold_valid;
  logic [CharW-1:0] hold_char;
  logic             out_free;
  logic             is_term;
  logic             advance;
  logic             res_load;
  res_t             result;

  // A byte that is not a terminator produces no item, so it always moves on.
  // A terminator moves on only when the result register can take its item.
  assign is_term  = (hold_char == ChNul);
  assign advance  = hold_valid && (!is_term || out_free);
  assign res_load = hold_valid && is_term && out_free;

  dip_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .char_in_i    (char_in_i),
    .advance_i    (advance),
    .in_stall_o   (in_stall_o),
    .hold_valid_o (hold_valid),
    .hold_char_o  (hold_char)
  );

  // The core updates its parser state on every byte that moves on and
  // clears it after a terminator.
  dip_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .char_i   (hold_char),
    .result_o (result)
  );

  dip_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (res_load),
    .result_i      (result),
    .out_stall_i   (out_stall_i),
    .free_o        (out_free),
    .out_valid_o   (out_valid_o),
    .address_o     (address_o),
    .parse_error_o (parse_error_o)
  );

`ifndef SYNTHESIS
  a_err_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && parse_error_o |-> address_o == '0)
    else $error("error item carries a nonzero address");

  a_stall_needs_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> hold_valid && is_term)
    else $error("input stalled without a waiting terminator");

  a_no_extra_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !res_load |=> !out_valid_o)
    else $error("result item repeated");
`endif

endmodule

@@ rtl/dip_in_reg.sv @@
// Input register of the dotted IPv4 text parser: holds one byte for the core.
// Depends on dip_pkg.
module dip_in_reg import dip_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [CharW-1:0] char_in_i,
  input  logic             advance_i,
  output logic             in_stall_o,
  output logic             hold_valid_o,
  output logic [CharW-1:0] hold_char_o
);

  logic             valid_q, valid_d;
  logic [CharW-1:0] char_q;
  logic             load;

  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= char_in_i;
    end
  end

  assign hold_valid_o = valid_q;
  assign hold_char_o  = char_q;

endmodule

@@ rtl/dip_core.sv @@
// Parser state and per-byte update of the dotted IPv4 text parser.
// Depends on dip_pkg.
module dip_core import dip_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [CharW-1:0] char_i,
  output res_t             result_o
);

  logic [1:0]        phase_q, phase_d;
  logic [1:0]        radix_q, radix_d;
  logic [AddrW-1:0]  value_q, value_d;
  logic [CountW-1:0] parts_q, parts_d;
  logic [PartW-1:0]  first_q, first_d;
  logic [PartW-1:0]  second_q, second_d;
  logic [PartW-1:0]  third_q, third_d;
  logic [1:0]        status_q, status_d;

  logic             is_dig, is_hex_lc, is_hex_uc, is_x, is_space;
  logic [3:0]       dval;
  logic [AddrW-1:0] scaled;
  logic             use_loop;

  assign is_dig    = (char_i >= ChZero) && (char_i <= ChNine);
  assign is_hex_lc = (radix_q == RX_HEX) && (char_i >= ChLowA) && (char_i <= ChLowF);
  assign is_hex_uc = (radix_q == RX_HEX) && (char_i >= ChUpA) && (char_i <= ChUpF);
  assign is_x      = (char_i == ChLowX) || (char_i == ChUpX);
  assign is_space  = (char_i == ChSpace) || ((char_i >= ChTab) && (char_i <= ChCr));

  always_comb begin
    dval = 4'd0;
    if (is_dig) begin
      dval = 4'(char_i - ChZero);
    end else if (is_hex_lc) begin
      dval = 4'(char_i - ChLowA + 8'd10);
    end else if (is_hex_uc) begin
      dval = 4'(char_i - ChUpA + 8'd10);
    end
  end

  // Constant-radix scaling is a shift or a shift-add; wraps at 32 bits.
  always_comb begin
    case (radix_q)
      RX_HEX:  scaled = value_q << 4;
      RX_OCT:  scaled = value_q << 3;
      default: scaled = (value_q << 3) + (value_q << 1);
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    radix_d  = radix_q;
    value_d  = value_q;
    parts_d  = parts_q;
    first_d  = first_q;
    second_d = second_q;
    third_d  = third_q;
    status_d = status_q;
    use_loop = 1'b0;

    if (char_i == ChNul) begin
      phase_d  = PH_START;
      radix_d  = RX_DEC;
      value_d  = '0;
      parts_d  = '0;
      first_d  = '0;
      second_d = '0;
      third_d  = '0;
      status_d = ST_RUN;
    end else if (status_q == ST_RUN) begin
      case (phase_q)
        PH_START: begin
          if (char_i == ChZero) begin
            radix_d = RX_OCT;
            phase_d = PH_ZERO;
          end else if (is_x) begin
            radix_d = RX_HEX;
            phase_d = PH_DIGITS;
          end else begin
            phase_d  = PH_DIGITS;
            use_loop = 1'b1;
          end
        end
        PH_ZERO: begin
          phase_d = PH_DIGITS;
          if (is_x) begin
            radix_d = RX_HEX;
          end else begin
            use_loop = 1'b1;
          end
        end
        default: begin
          use_loop = 1'b1;
        end
      endcase

      if (use_loop) begin
        if (is_dig || is_hex_lc || is_hex_uc) begin
          value_d = scaled + AddrW'(dval);
        end else if (char_i == ChDot) begin
          if (parts_q >= MaxParts) begin
            status_d = ST_ERR;
          end else begin
            case (parts_q)
              3'd0:    first_d  = value_q[PartW-1:0];
              3'd1:    second_d = value_q[PartW-1:0];
              3'd2:    third_d  = value_q[PartW-1:0];
              default: ;
            endcase
            parts_d = parts_q + 3'd1;
            value_d = '0;
            radix_d = RX_DEC;
            phase_d = PH_START;
          end
        end else if (is_space) begin
          status_d = ST_STOP;
        end else begin
          status_d = ST_ERR;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_START;
      radix_q  <= RX_DEC;
      value_q  <= '0;
      parts_q  <= '0;
      first_q  <= '0;
      second_q <= '0;
      third_q  <= '0;
      status_q <= ST_RUN;
    end else if (step_i) begin
      phase_q  <= phase_d;
      radix_q  <= radix_d;
      value_q  <= value_d;
      parts_q  <= parts_d;
      first_q  <= first_d;
      second_q <= second_d;
      third_q  <= third_d;
      status_q <= status_d;
    end
  end

  // Packing of the result from the current state, used on the terminator.
  always_comb begin
    result_o = '0;
    if ((status_q == ST_ERR) || (parts_q >= MaxParts)) begin
      result_o.parse_error = 1'b1;
    end else begin
      case (parts_q)
        3'd0:    result_o.address = value_q;
        3'd1:    result_o.address = {first_q, value_q[23:0]};
        3'd2:    result_o.address = {first_q, second_q, value_q[15:0]};
        default: result_o.address = {first_q, second_q, third_q, value_q[7:0]};
      endcase
    end
  end

`ifndef SYNTHESIS
  a_parts_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    parts_q <= MaxParts)
    else $error("part count exceeds four");
`endif

endmodule

@@ rtl/dip_out_reg.sv @@
// Result register of the dotted IPv4 text parser; parts the core from the
// downstream stall. Depends on dip_pkg.
module dip_out_reg import dip_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  res_t             result_i,
  input  logic             out_stall_i,
  output logic             free_o,
  output logic             out_valid_o,
  output logic [AddrW-1:0] address_o,
  output logic             parse_error_o
);

  logic valid_q, valid_d;
  res_t res_q;

  assign free_o  = !valid_q || !out_stall_i;
  assign valid_d = load_i || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o   = valid_q;
  assign address_o     = res_q.address;
  assign parse_error_o = res_q.parse_error;

endmodule
